@@ rtl/pat_pkg.sv @@
package pat_pkg;

   localparam int TABLE_ENTRIES_DEF = 16;

   localparam logic KIND_PREPARE = 1'b0;
   localparam logic KIND_ACCEPT  = 1'b1;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_REJECT = 2'd1;
   localparam logic [1:0] STATUS_FULL   = 2'd2;

   typedef struct packed {
      logic        kind;
      logic [63:0] instance_id;
      logic [63:0] ballot;
      logic [63:0] value_hash;
   } req_type;

   typedef struct packed {
      logic [63:0] out_instance;
      logic [63:0] out_ballot;
      logic [63:0] promised_ballot;
      logic [63:0] accepted_ballot;
      logic [63:0] accepted_hash;
      logic [1:0]  status;
   } rsp_type;

   // One row of the acceptor table, held in a single RAM word.
   typedef struct packed {
      logic [63:0] key;
      logic [63:0] promise;
      logic        has_accepted;
      logic [63:0] acc_ballot;
      logic [63:0] acc_hash;
   } entry_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic decide;
   } cmd_type;

   typedef struct packed {
      logic fill_zero;
      logic scan_hit;
      logic scan_last;
   } sts_type;

endpackage

@@ rtl/pat_ram.sv @@
module pat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/pat_datapath.sv @@
module pat_datapath #(
   parameter int TABLE_ENTRIES = pat_pkg::TABLE_ENTRIES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  pat_pkg::req_type req_data,
   input  pat_pkg::cmd_type cmd,
   output pat_pkg::sts_type sts,
   output pat_pkg::rsp_type rsp_data
);

   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int EW = $bits(pat_pkg::entry_type);

   pat_pkg::req_type   req_ff;
   pat_pkg::rsp_type   rsp_ff;
   pat_pkg::rsp_type   rsp_in;
   pat_pkg::entry_type entry_ff;
   pat_pkg::entry_type rd_entry;
   pat_pkg::entry_type wr_entry;

   logic [CW-1:0] fill_ff;
   logic [CW-1:0] addr_ff;
   logic          cmp_valid_ff;
   logic [IW-1:0] cmp_idx_ff;
   logic          found_ff;
   logic [IW-1:0] slot_ff;

   logic          issue;
   logic          rd_en;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [EW-1:0] rd_word;

   logic [63:0]   promise;
   logic          have_prior;
   logic [63:0]   prior_ballot;
   logic [63:0]   prior_hash;
   logic          is_accept;
   logic          grant;
   logic          need_claim;
   logic          full;

   // Entries are claimed lowest index first and never freed, so the valid
   // entries are exactly those below the fill count.
   assign issue   = addr_ff < fill_ff;
   assign rd_en   = cmd.scan && issue;
   assign rd_entry = pat_pkg::entry_type'(rd_word);

   assign sts.fill_zero = (fill_ff == '0);
   assign sts.scan_hit  = cmp_valid_ff && (rd_entry.key == req_ff.instance_id);
   assign sts.scan_last = cmp_valid_ff && ((CW'(cmp_idx_ff) + CW'(1)) == fill_ff);

   always_comb begin
      promise      = found_ff ? entry_ff.promise : 64'd0;
      have_prior   = found_ff && (promise != 64'd0) && entry_ff.has_accepted;
      prior_ballot = have_prior ? entry_ff.acc_ballot : 64'd0;
      prior_hash   = have_prior ? entry_ff.acc_hash : 64'd0;
      is_accept    = (req_ff.kind == pat_pkg::KIND_ACCEPT);
      grant        = is_accept ? (promise <= req_ff.ballot) : (promise < req_ff.ballot);
      need_claim   = grant && !found_ff;
      full         = need_claim && (fill_ff == CW'(TABLE_ENTRIES));

      rsp_in.out_instance = req_ff.instance_id;
      rsp_in.out_ballot   = req_ff.ballot;
      if (full) begin
         rsp_in.promised_ballot = 64'd0;
         rsp_in.accepted_ballot = 64'd0;
         rsp_in.accepted_hash   = 64'd0;
         rsp_in.status          = pat_pkg::STATUS_FULL;
      end else begin
         rsp_in.promised_ballot = (is_accept || grant) ? req_ff.ballot : promise;
         rsp_in.accepted_ballot = is_accept ? req_ff.ballot : prior_ballot;
         rsp_in.accepted_hash   = prior_hash;
         rsp_in.status          = grant ? pat_pkg::STATUS_OK : pat_pkg::STATUS_REJECT;
      end

      // A freshly claimed row starts with nothing accepted unless the claiming request is an accept.
      wr_en                 = cmd.decide && grant && !full;
      wr_addr               = found_ff ? slot_ff : fill_ff[IW-1:0];
      wr_entry.key          = req_ff.instance_id;
      wr_entry.promise      = req_ff.ballot;
      wr_entry.has_accepted = is_accept || (found_ff && entry_ff.has_accepted);
      wr_entry.acc_ballot   = is_accept ? req_ff.ballot
                                        : (found_ff ? entry_ff.acc_ballot : 64'd0);
      wr_entry.acc_hash     = is_accept ? req_ff.value_hash
                                        : (found_ff ? entry_ff.acc_hash : 64'd0);
   end

   pat_ram #(
      .WIDTH (EW),
      .DEPTH (TABLE_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (EW'(wr_entry)),
      .rd_en   (rd_en),
      .rd_addr (addr_ff[IW-1:0]),
      .rd_data (rd_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         addr_ff      <= '0;
         cmp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         if (cmd.load) begin
            addr_ff      <= '0;
            cmp_valid_ff <= 1'b0;
            found_ff     <= 1'b0;
         end else if (cmd.scan) begin
            if (issue) begin
               addr_ff <= addr_ff + CW'(1);
            end
            cmp_valid_ff <= issue;
            if (sts.scan_hit) begin
               found_ff <= 1'b1;
            end
         end
         if (wr_en && need_claim) begin
            fill_ff <= fill_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.scan) begin
         cmp_idx_ff <= addr_ff[IW-1:0];
         if (sts.scan_hit) begin
            slot_ff  <= cmp_idx_ff;
            entry_ff <= rd_entry;
         end
      end
      if (cmd.decide) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

@@ rtl/pat_ctrl.sv @@
module pat_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  pat_pkg::sts_type sts,
   output pat_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DECIDE = 4'b0100,
      ST_RESP   = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      rsp_valid  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sts.fill_zero ? ST_DECIDE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_hit || sts.scan_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/paxos_acceptor_table.sv @@
// Flow, without result stalls: a word accepted with the table empty goes straight to the decide
// step; otherwise the key scan runs first, one RAM read per entry in use, ending at a key match
// or at the last entry in use. The result is then registered and held until it is taken.
// Throughput: one word at a time; the next word is taken the cycle after the result leaves.
// Reset is synchronous and active high; it empties the table and idles the controller.
module paxos_acceptor_table #(
   parameter int TABLE_ENTRIES = pat_pkg::TABLE_ENTRIES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pat_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pat_pkg::rsp_type rsp_data
);

   pat_pkg::cmd_type cmd;
   pat_pkg::sts_type sts;

   pat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   pat_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

@@ rtl/pat_checker.sv @@
module pat_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input pat_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input pat_pkg::rsp_type rsp_data
);

   // Only one word is in flight, so the input side waits while a result is shown.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while a result is pending");

   a_full_zeroes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == pat_pkg::STATUS_FULL) |->
      (rsp_data.promised_ballot == 64'd0 && rsp_data.accepted_ballot == 64'd0 &&
       rsp_data.accepted_hash == 64'd0))
      else $error("table full result carries nonzero fields");

   // A granted request always leaves its own ballot as the promise.
   a_ok_promise: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == pat_pkg::STATUS_OK) |->
      (rsp_data.promised_ballot == rsp_data.out_ballot))
      else $error("granted result does not promise its ballot");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result word changed or dropped");

endmodule

bind paxos_acceptor_table pat_checker u_checker (.*);
